### hdl/cdz_pkg.sv
// ----------------------------------------------------------------------------
// cdz_pkg - camera dead-zone follower shared definitions
// Widths, fixed-point constants, configuration codes and the helpers that
// turn the view size registers into the per-frame geometry constants.
// ----------------------------------------------------------------------------
package cdz_pkg;

    localparam int FRAC_BITS = 8;
    localparam int CFG_W     = 12;
    localparam int POS_W     = 32;
    localparam int DIF_W     = POS_W + 1;

    // Width in Q format and the quantities taken from it
    localparam int W_W    = CFG_W + FRAC_BITS;
    localparam int HALF_W = W_W - 1;
    localparam int RNG_W  = HALF_W - 1;
    localparam int LIM_W  = W_W - 3;
    localparam int ZS_W   = LIM_W + 1;

    // Twice the height in Q format, and two thirds of the height
    localparam int Y2_W   = CFG_W + FRAC_BITS + 1;
    localparam int YOFF_W = Y2_W - 1;

    // Divide by three as multiply by ceil(2^n/3), exact for x < 2^(n-1)
    localparam int RNG_SH  = HALF_W + 1;
    localparam int YOFF_SH = Y2_W + 1;
    localparam longint unsigned RNG_MUL  = ((64'd1 << RNG_SH) + 64'd2) / 64'd3;
    localparam longint unsigned YOFF_MUL = ((64'd1 << YOFF_SH) + 64'd2) / 64'd3;

    localparam int NEAR_PX  = 10;
    localparam int NEAR_Q   = NEAR_PX << FRAC_BITS;
    localparam int LIM_MAX  = ((1 << CFG_W) - 1) << FRAC_BITS >> 3;
    localparam int X_SHIFT  = 5;
    localparam int Y_SHIFT  = 4;
    localparam int ZS_SHIFT = 5;

    localparam logic [CFG_W-1:0] VIEW_WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] VIEW_HEIGHT_RST = CFG_W'(360);

    typedef enum logic [0:0] {
        CFG_VIEW_WIDTH  = 1'b0,
        CFG_VIEW_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic [RNG_W-1:0]  rng;
        logic [LIM_W-1:0]  lim;
        logic [YOFF_W-1:0] yoff;
    } t_geom;

    typedef struct packed {
        logic [POS_W-1:0] target_x;
        logic [POS_W-1:0] target_y;
        logic             facing_left;
        logic             airborne;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0] view_origin_x;
        logic [POS_W-1:0] view_origin_y;
        logic [POS_W-1:0] zone_left;
        logic [POS_W-1:0] zone_right;
        logic             following_x;
    } t_result;

    function automatic t_geom set_width(input t_geom g, input logic [CFG_W-1:0] vw);
        t_geom                     r;
        logic [W_W-1:0]            wq;
        logic [HALF_W+RNG_SH-1:0]  prod;
        r    = g;
        wq   = W_W'(vw) << FRAC_BITS;
        r.half = wq[W_W-1:1];
        prod = (HALF_W+RNG_SH)'(r.half) * (HALF_W+RNG_SH)'(RNG_MUL);
        r.rng  = RNG_W'(prod >> RNG_SH);
        r.lim  = wq[W_W-1:3];
        return r;
    endfunction

    function automatic t_geom set_height(input t_geom g, input logic [CFG_W-1:0] vh);
        t_geom                    r;
        logic [Y2_W-1:0]          h2;
        logic [Y2_W+YOFF_SH-1:0]  prod;
        r    = g;
        h2   = Y2_W'(vh) << (FRAC_BITS + 1);
        prod = (Y2_W+YOFF_SH)'(h2) * (Y2_W+YOFF_SH)'(YOFF_MUL);
        r.yoff = YOFF_W'(prod >> YOFF_SH);
        return r;
    endfunction

endpackage

### hdl/cdz_core.sv
// ----------------------------------------------------------------------------
// cdz_core - camera follow state and per-frame update
// Holds camera position, focus offset and the x hysteresis flag, and works
// out the next state and the result fields for the item in the input stage.
// ----------------------------------------------------------------------------
module cdz_core
    import cdz_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    input  t_geom   i_geom,
    output t_result o_result
);

    logic signed [POS_W-1:0] r_cam_x, n_cam_x;
    logic signed [POS_W-1:0] r_cam_y, n_cam_y;
    logic signed [ZS_W-1:0]  r_zs,    n_zs;
    logic                    r_flag,  n_flag;

    logic signed [POS_W-1:0] tx, ty;
    logic signed [ZS_W:0]    lim_s, zs_goal, zs_diff;
    logic [ZS_W:0]           zs_mag;
    logic                    zs_move;
    logic signed [DIF_W-1:0] dx, dy, rng_s, near_s;
    logic                    far_x, near_x;
    logic [POS_W-1:0]        half_e, rng_e, zs_e, yoff_e;

    always_comb begin
        tx = $signed(i_item.target_x);
        ty = $signed(i_item.target_y);

        // Focus offset eases toward the facing side, frozen at or past the limit
        lim_s   = $signed((ZS_W+1)'(i_geom.lim));
        zs_goal = i_item.facing_left ? lim_s : -lim_s;
        zs_diff = zs_goal - (ZS_W+1)'(r_zs);
        zs_mag  = r_zs[ZS_W-1] ? $unsigned(-((ZS_W+1)'(r_zs))) : $unsigned((ZS_W+1)'(r_zs));
        zs_move = zs_mag < (ZS_W+1)'(i_geom.lim);
        n_zs    = zs_move ? r_zs + ZS_W'(zs_diff >>> ZS_SHIFT) : r_zs;

        // Horizontal hysteresis
        dx     = DIF_W'(tx) - DIF_W'(r_cam_x);
        rng_s  = $signed(DIF_W'(i_geom.rng));
        near_s = $signed(DIF_W'(NEAR_Q));
        far_x  = (dx < -rng_s) || (dx > rng_s);
        near_x = (dx > -near_s) && (dx < near_s);
        priority if (far_x) begin
            n_flag = 1'b1;
        end else if (near_x) begin
            n_flag = 1'b0;
        end else begin
            n_flag = r_flag;
        end
        n_cam_x = n_flag ? r_cam_x + POS_W'(dx >>> X_SHIFT) : r_cam_x;

        // Vertical follow, held while airborne
        dy      = DIF_W'(ty) - DIF_W'(r_cam_y);
        n_cam_y = i_item.airborne ? r_cam_y : r_cam_y + POS_W'(dy >>> Y_SHIFT);

        half_e = POS_W'(i_geom.half);
        rng_e  = POS_W'(i_geom.rng);
        zs_e   = POS_W'(n_zs);
        yoff_e = POS_W'(i_geom.yoff);

        o_result.view_origin_x = $unsigned(n_cam_x) - half_e - zs_e;
        o_result.view_origin_y = $unsigned(n_cam_y) - yoff_e;
        o_result.zone_left     = half_e - rng_e + zs_e;
        o_result.zone_right    = half_e + rng_e + zs_e;
        o_result.following_x   = n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_zs    <= '0;
            r_flag  <= 1'b0;
        end else if (i_adv) begin
            r_cam_x <= n_cam_x;
            r_cam_y <= n_cam_y;
            r_zs    <= n_zs;
            r_flag  <= n_flag;
        end
    end

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_cam_x) && $stable(r_cam_y) && $stable(r_zs) && $stable(r_flag))
        else $error("follow state changed without a beat");

    a_zs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_zs <= ZS_W'(LIM_MAX)) && (r_zs >= -ZS_W'(LIM_MAX)))
        else $error("focus offset beyond the largest limit");

    a_x_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !n_flag |=> r_cam_x == $past(r_cam_x))
        else $error("camera x moved while not following");

    a_y_air: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.airborne |=> r_cam_y == $past(r_cam_y))
        else $error("camera y moved while airborne");

    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && far_x |=> r_flag)
        else $error("hysteresis flag not set on a far target");

endmodule

### hdl/camera_deadzone_follow_unit.sv
// ----------------------------------------------------------------------------
// camera_deadzone_follow_unit - dead-zone camera follow, one frame per beat
// Top level: configuration registers, input stage and result register
// around the follow core.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one frame's target:
//   position in signed Q23.8, facing-left and airborne flags.
//   Output channel (o_out_valid / i_out_ready) returns view origin, focus
//   zone edges and the x follow flag for that frame.
//   A beat accepted into the input stage moves to the result register, with
//   o_out_valid high, when that register is free or being taken.
//   Throughput: one beat per cycle while the receiver takes every result;
//   the registered update loop on the camera state sets that rate.
//   Stall: when the receiver holds i_out_ready low the result is held, the
//   input stage fills, and o_in_ready drops until the result is taken.
//   Configuration: write i_cfg_data to register i_cfg_idx (view width, view
//   height) with i_cfg_we while no beat is in flight; derived geometry is
//   registered on the write.
//   Reset (synchronous, active low) empties both stages, zeroes the camera
//   state and loads a 640 x 360 view.
// ----------------------------------------------------------------------------
module camera_deadzone_follow_unit
    import cdz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,

    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [POS_W-1:0] i_target_x,
    input  logic [POS_W-1:0] i_target_y,
    input  logic             i_facing_left,
    input  logic             i_airborne,

    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [POS_W-1:0] o_view_origin_x,
    output logic [POS_W-1:0] o_view_origin_y,
    output logic [POS_W-1:0] o_zone_left,
    output logic [POS_W-1:0] o_zone_right,
    output logic             o_following_x
);

    t_geom   r_geom, n_geom;
    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result core_result;
    logic    adv;

    // Advance the input stage when the result register is free or being taken
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_comb begin
        n_geom = r_geom;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_VIEW_WIDTH:  n_geom = set_width(r_geom, i_cfg_data);
                CFG_VIEW_HEIGHT: n_geom = set_height(r_geom, i_cfg_data);
                default:         n_geom = r_geom;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= set_height(set_width('0, VIEW_WIDTH_RST), VIEW_HEIGHT_RST);
        end else begin
            r_geom <= n_geom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.target_x    <= i_target_x;
            r_item.target_y    <= i_target_y;
            r_item.facing_left <= i_facing_left;
            r_item.airborne    <= i_airborne;
        end
        if (adv) begin
            r_result <= core_result;
        end
    end

    cdz_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_item),
        .i_geom   (r_geom),
        .o_result (core_result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_view_origin_x = r_result.view_origin_x;
    assign o_view_origin_y = r_result.view_origin_y;
    assign o_zone_left     = r_result.zone_left;
    assign o_zone_right    = r_result.zone_right;
    assign o_following_x   = r_result.following_x;

endmodule
